### rtl/core/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg
// Types and constants shared by the bounded priority queue and its cells.
// ----------------------------------------------------------------------------
package bpq_pkg;

    localparam int DEPTH        = 16;
    localparam int PRIO_BITS    = 8;
    localparam int PAYLOAD_BITS = 16;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);

    typedef enum logic
    {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic [PAYLOAD_BITS-1:0] msg_handle;
        logic [PAYLOAD_BITS-1:0] dest;
        logic [PRIO_BITS-1:0]    prio;
    } entry_t;

    typedef struct packed
    {
        kind_t                   kind;
        logic [PAYLOAD_BITS-1:0] msg_handle;
        logic [PAYLOAD_BITS-1:0] dest;
        logic [PRIO_BITS-1:0]    prio;
    } cmd_t;

    typedef struct packed
    {
        logic                    ok;
        logic [PAYLOAD_BITS-1:0] msg_out;
        logic [PAYLOAD_BITS-1:0] dest_out;
        logic                    is_empty;
        logic [CNT_BITS-1:0]     fill;
    } res_t;

    typedef struct packed
    {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } ctrl_t;

endpackage

### rtl/core/bpq_cell.sv
// ----------------------------------------------------------------------------
// bpq_cell
// One slot of the sorted row: holds an entry, shifts left or right with its
// neighbors, or takes the new entry at the insertion point.
// ----------------------------------------------------------------------------
module bpq_cell
(
    input  logic            clk,
    input  bpq_pkg::ctrl_t  ctrl,
    input  logic            occ,
    input  logic            left_behind,
    input  bpq_pkg::entry_t left_entry,
    input  bpq_pkg::entry_t right_entry,
    output logic            behind,
    output bpq_pkg::entry_t entry
);

    bpq_pkg::entry_t entry_reg;
    bpq_pkg::entry_t entry_next;

    // new entry goes behind this one when held priority is not lower
    assign behind = occ && (entry_reg.prio >= ctrl.new_entry.prio);
    assign entry  = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.enq && !behind)
        begin
            if (left_behind)
            begin
                entry_next = ctrl.new_entry;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/core/bounded_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// bounded_priority_queue_unit
// Bounded priority queue kept sorted in a row of shifting cells; equal
// priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------------
//  command | cmd_valid | cmd_stall | cmd (kind, msg_handle, dest, prio)
//  result  | res_valid | res_stall | res (ok, msg_out, dest_out, is_empty, fill)
//
//  One command per cycle while cmd_stall is low: every cell compares
//  against the new priority and shifts in the same cycle.
//  The result appears in the output register in the cycle after the transfer.
//  Reset clears the entry count and the result valid; cell contents are
//  written before they are read.
//  A held result stalls the command side only while res_stall is high.
// ----------------------------------------------------------------------------
module bounded_priority_queue_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  bpq_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output bpq_pkg::res_t res
);

    logic [bpq_pkg::CNT_BITS-1:0] count_reg;
    logic [bpq_pkg::CNT_BITS-1:0] count_next;
    logic                         res_valid_reg;
    logic                         res_valid_next;
    bpq_pkg::res_t                res_reg;
    bpq_pkg::res_t                res_next;

    logic                         cmd_fire;
    logic                         full;
    logic                         empty;
    bpq_pkg::ctrl_t               ctrl;

    logic [bpq_pkg::DEPTH-1:0]    occ;
    logic [bpq_pkg::DEPTH-1:0]    behind;
    bpq_pkg::entry_t              cell_entry [bpq_pkg::DEPTH];

    assign cmd_stall = res_valid_reg && res_stall;
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign full      = (count_reg == bpq_pkg::CNT_BITS'(bpq_pkg::DEPTH));
    assign empty     = (count_reg == '0);

    assign ctrl.enq                  = cmd_fire && (cmd.kind == bpq_pkg::KIND_ENQ) && !full;
    assign ctrl.deq                  = cmd_fire && (cmd.kind == bpq_pkg::KIND_DEQ) && !empty;
    assign ctrl.new_entry.msg_handle = cmd.msg_handle;
    assign ctrl.new_entry.dest       = cmd.dest;
    assign ctrl.new_entry.prio       = cmd.prio;

    genvar gi;
    generate
        for (gi = 0; gi < bpq_pkg::DEPTH; gi++)
        begin : g_cell
            logic            left_behind;
            bpq_pkg::entry_t left_entry;
            bpq_pkg::entry_t right_entry;

            assign occ[gi] = (bpq_pkg::CNT_BITS'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_behind = 1'b1;
                assign left_entry  = cell_entry[gi];
            end
            else
            begin : g_body
                assign left_behind = behind[gi-1];
                assign left_entry  = cell_entry[gi-1];
            end

            if (gi == bpq_pkg::DEPTH - 1)
            begin : g_tail
                assign right_entry = cell_entry[gi];
            end
            else
            begin : g_mid
                assign right_entry = cell_entry[gi+1];
            end

            bpq_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occ         (occ[gi]),
                .left_behind (left_behind),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .behind      (behind[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + bpq_pkg::CNT_BITS'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - bpq_pkg::CNT_BITS'(1);
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (cmd_fire)
        begin
            res_valid_next    = 1'b1;
            res_next.ok       = ctrl.enq || ctrl.deq;
            res_next.msg_out  = ctrl.deq ? cell_entry[0].msg_handle : '0;
            res_next.dest_out = ctrl.deq ? cell_entry[0].dest : '0;
            res_next.is_empty = (count_next == '0);
            res_next.fill     = count_next;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bpq_pkg::CNT_BITS'(bpq_pkg::DEPTH))
        else $error("entry count above depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.enq |=> (count_reg == $past(count_reg) + bpq_pkg::CNT_BITS'(1)))
        else $error("enqueue did not add an entry");

    a_deq_empty_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.kind == bpq_pkg::KIND_DEQ) && empty) |=> !res_reg.ok)
        else $error("dequeue from empty queue reported success");

    a_res_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.is_empty == (res_reg.fill == '0)))
        else $error("empty flag disagrees with fill");

endmodule
